FILE: src/hc_pkg.sv
// shared types, register indexes, status codes and byte arithmetic helpers
// for the 2x2 byte hill cipher; no dependencies
`default_nettype none

package hc_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd4;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_KEY = 2'd1;
  localparam logic [1:0] STAT_ODD = 2'd2;
  localparam logic [1:0] STAT_PAD = 2'd3;

  // working matrix [a b; c d]
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
  } wm_t;

  // matrix unit status toward the front end and core
  typedef struct packed {
    logic dec_cfg;
    logic dec_msg;
    logic setup;
    logic key_bad;
  } mctl_t;

  // one item that closes a pair or ends a message
  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic       last;
    logic       dec;
    logic       pend;
    logic       held;
  } job_t;

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       last;
    logic [1:0] status;
  } res_t;

  typedef logic [127:0][7:0] inv_tbl_t;

  function automatic logic [7:0] mul8(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] p;
    p = a * b;
    return p[7:0];
  endfunction

  // inverse mod 256 of odd value 2*i+1, newton iteration
  function automatic inv_tbl_t build_inv_tbl();
    inv_tbl_t   t;
    logic [7:0] v;
    logic [7:0] x;
    for (int i = 0; i < 128; i++) begin
      v = 8'(2 * i + 1);
      x = v;
      for (int k = 0; k < 3; k++) begin
        x = mul8(x, 8'd2 - mul8(v, x));
      end
      t[i] = x;
    end
    return t;
  endfunction

  localparam inv_tbl_t INV_TBL = build_inv_tbl();

endpackage

`default_nettype wire

FILE: src/hc_matrix.sv
// configuration registers and per-message working matrix setup
// depends on hc_pkg (types, register indexes, inverse table)
`default_nettype none

module hc_matrix (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                           start,
  output hc_pkg::wm_t                    wm,
  output hc_pkg::mctl_t                  ctl
);

  logic [7:0]  key_a_r, key_b_r, key_c_r, key_d_r;
  logic        mode_r;
  hc_pkg::wm_t wm_r;
  hc_pkg::wm_t inv_nxt;
  logic [6:0]  det_hi_r;
  logic        dec_msg_r;
  logic        setup_r;
  logic        kb_r;
  logic [7:0]  det;
  logic [7:0]  inv;

  assign det = hc_pkg::mul8(key_a_r, key_d_r) - hc_pkg::mul8(key_b_r, key_c_r);
  assign inv = hc_pkg::INV_TBL[det_hi_r];

  always_comb begin
    inv_nxt.a = hc_pkg::mul8(wm_r.d, inv);
    inv_nxt.b = hc_pkg::mul8(8'd0 - wm_r.b, inv);
    inv_nxt.c = hc_pkg::mul8(8'd0 - wm_r.c, inv);
    inv_nxt.d = hc_pkg::mul8(wm_r.a, inv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_a_r   <= 8'd1;
      key_b_r   <= 8'd0;
      key_c_r   <= 8'd0;
      key_d_r   <= 8'd1;
      mode_r    <= 1'b0;
      dec_msg_r <= 1'b0;
      setup_r   <= 1'b0;
      kb_r      <= 1'b0;
      wm_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hc_pkg::CFG_KEY_A: key_a_r <= cfg_data;
          hc_pkg::CFG_KEY_B: key_b_r <= cfg_data;
          hc_pkg::CFG_KEY_C: key_c_r <= cfg_data;
          hc_pkg::CFG_KEY_D: key_d_r <= cfg_data;
          hc_pkg::CFG_MODE:  mode_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (start) begin
        wm_r      <= '{a: key_a_r, b: key_b_r, c: key_c_r, d: key_d_r};
        det_hi_r  <= det[7:1];
        kb_r      <= ~det[0];
        dec_msg_r <= mode_r;
        setup_r   <= 1'b1;
      end else if (setup_r) begin
        setup_r <= 1'b0;
        if (dec_msg_r) begin
          wm_r <= kb_r ? '0 : inv_nxt;
        end
      end
    end
  end

  assign wm          = wm_r;
  assign ctl.dec_cfg = mode_r;
  assign ctl.dec_msg = dec_msg_r;
  assign ctl.setup   = setup_r;
  assign ctl.key_bad = kb_r;

endmodule

`default_nettype wire

FILE: src/hc_front.sv
// input side: byte pairing, message tracking and the job register
// depends on hc_pkg (job and control types)
`default_nettype none

module hc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_data_byte,
  input  logic          in_end_of_message,
  input  hc_pkg::mctl_t ctl,
  input  logic          job_take,
  output logic          start,
  output hc_pkg::job_t  job,
  output logic          job_valid
);

  logic         pend_r;
  logic [7:0]   pend_byte_r;
  logic         held_v_r;
  logic         active_r;
  logic         job_v_r;
  hc_pkg::job_t job_r;
  logic         accept;
  logic         dec;
  logic         makes_job;

  assign in_stall  = ctl.setup || (job_v_r && !job_take);
  assign accept    = in_valid && !in_stall;
  assign start     = accept && !active_r;
  assign dec       = active_r ? ctl.dec_msg : ctl.dec_cfg;
  assign makes_job = pend_r || in_end_of_message;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 1'b0;
      held_v_r <= 1'b0;
      active_r <= 1'b0;
      job_v_r  <= 1'b0;
    end else begin
      if (accept && makes_job) begin
        job_v_r <= 1'b1;
      end else if (job_take) begin
        job_v_r <= 1'b0;
      end
      if (accept) begin
        if (in_end_of_message) begin
          pend_r   <= 1'b0;
          held_v_r <= 1'b0;
          active_r <= 1'b0;
        end else begin
          active_r <= 1'b1;
          if (pend_r) begin
            pend_r <= 1'b0;
            if (dec) begin
              held_v_r <= 1'b1;
            end
          end else begin
            pend_r <= 1'b1;
          end
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!pend_r) begin
        pend_byte_r <= in_data_byte;
      end
      if (makes_job) begin
        job_r.x    <= pend_r ? pend_byte_r : in_data_byte;
        job_r.y    <= pend_r ? in_data_byte : 8'd1;
        job_r.last <= in_end_of_message;
        job_r.dec  <= dec;
        job_r.pend <= pend_r;
        job_r.held <= held_v_r;
      end
    end
  end

  assign job       = job_r;
  assign job_valid = job_v_r;

endmodule

`default_nettype wire

FILE: src/hc_core.sv
// pair transform, result group building and result sequencing
// depends on hc_pkg (types, status codes, mul8)
`default_nettype none

module hc_core (
  input  logic          clk,
  input  logic          rst_n,
  input  hc_pkg::job_t  job,
  input  logic          job_valid,
  input  hc_pkg::wm_t   wm,
  input  hc_pkg::mctl_t ctl,
  output logic          job_take,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_byte_valid,
  output logic          out_last_of_message,
  output logic [1:0]    out_status
);

  function automatic hc_pkg::res_t mk_res(input logic [7:0] d, input logic v,
                                          input logic l, input logic [1:0] s);
    hc_pkg::res_t r;
    r.data   = d;
    r.vld    = v;
    r.last   = l;
    r.status = s;
    return r;
  endfunction

  hc_pkg::res_t grp_r [4];
  hc_pkg::res_t grp_nxt [4];
  logic [1:0]   idx_r;
  logic [1:0]   lastidx_r;
  logic         grp_v_r;
  logic [15:0]  held_pair_r;
  logic [2:0]   n;
  logic [7:0]   p_hi, p_lo, t_hi, t_lo, sum_ab, sum_cd;
  logic         free;
  logic         kb;

  assign kb     = ctl.key_bad;
  assign p_hi   = hc_pkg::mul8(wm.a, job.x) + hc_pkg::mul8(wm.b, job.y);
  assign p_lo   = hc_pkg::mul8(wm.c, job.x) + hc_pkg::mul8(wm.d, job.y);
  assign sum_ab = wm.a + wm.b;
  assign sum_cd = wm.c + wm.d;
  assign t_hi   = {sum_ab[6:0], 1'b0};
  assign t_lo   = {sum_cd[6:0], 1'b0};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      grp_nxt[i] = '0;
    end
    n = 3'd0;
    if (!job.dec) begin
      if (!job.pend) begin
        if (kb) begin
          grp_nxt[n[1:0]] = mk_res(8'd0, 1'b0, 1'b1, hc_pkg::STAT_KEY);
          n = n + 3'd1;
        end else begin
          grp_nxt[n[1:0]] = mk_res(p_hi, 1'b1, 1'b0, hc_pkg::STAT_OK);
          n = n + 3'd1;
          grp_nxt[n[1:0]] = mk_res(p_lo, 1'b1, 1'b1, hc_pkg::STAT_OK);
          n = n + 3'd1;
        end
      end else begin
        grp_nxt[n[1:0]] = mk_res(p_hi, 1'b1, 1'b0, hc_pkg::STAT_OK);
        n = n + 3'd1;
        grp_nxt[n[1:0]] = mk_res(p_lo, 1'b1, 1'b0, hc_pkg::STAT_OK);
        n = n + 3'd1;
        if (job.last) begin
          if (kb) begin
            grp_nxt[n[1:0]] = mk_res(8'd0, 1'b0, 1'b1, hc_pkg::STAT_KEY);
            n = n + 3'd1;
          end else begin
            grp_nxt[n[1:0]] = mk_res(t_hi, 1'b1, 1'b0, hc_pkg::STAT_OK);
            n = n + 3'd1;
            grp_nxt[n[1:0]] = mk_res(t_lo, 1'b1, 1'b1, hc_pkg::STAT_OK);
            n = n + 3'd1;
          end
        end
      end
    end else begin
      if (job.held) begin
        grp_nxt[n[1:0]] = mk_res(held_pair_r[15:8], 1'b1, 1'b0, hc_pkg::STAT_OK);
        n = n + 3'd1;
        grp_nxt[n[1:0]] = mk_res(held_pair_r[7:0], 1'b1, 1'b0, hc_pkg::STAT_OK);
        n = n + 3'd1;
      end
      if (!job.pend) begin
        grp_nxt[n[1:0]] = mk_res(8'd0, 1'b0, 1'b1,
                                 kb ? hc_pkg::STAT_KEY : hc_pkg::STAT_ODD);
        n = n + 3'd1;
      end else if (job.last) begin
        if (kb) begin
          grp_nxt[n[1:0]] = mk_res(8'd0, 1'b0, 1'b1, hc_pkg::STAT_KEY);
        end else if (p_lo == 8'd1) begin
          grp_nxt[n[1:0]] = mk_res(p_hi, 1'b1, 1'b1, hc_pkg::STAT_OK);
        end else if (p_lo == 8'd2 && p_hi == 8'd2) begin
          grp_nxt[n[1:0]] = mk_res(8'd0, 1'b0, 1'b1, hc_pkg::STAT_OK);
        end else begin
          grp_nxt[n[1:0]] = mk_res(8'd0, 1'b0, 1'b1, hc_pkg::STAT_PAD);
        end
        n = n + 3'd1;
      end
    end
  end

  // group slot frees when its final result transfers
  assign free     = !grp_v_r || (!out_stall && idx_r == lastidx_r);
  assign job_take = job_valid && !ctl.setup && free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_v_r   <= 1'b0;
      idx_r     <= 2'd0;
      lastidx_r <= 2'd0;
    end else if (job_take) begin
      grp_v_r   <= n != 3'd0;
      idx_r     <= 2'd0;
      lastidx_r <= 2'(n - 3'd1);
    end else if (grp_v_r && !out_stall) begin
      if (idx_r == lastidx_r) begin
        grp_v_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (job_take) begin
      for (int i = 0; i < 4; i++) begin
        grp_r[i] <= grp_nxt[i];
      end
      if (job.dec && job.pend) begin
        held_pair_r <= {p_hi, p_lo};
      end
    end
  end

  assign out_valid           = grp_v_r;
  assign out_byte            = grp_r[idx_r].data;
  assign out_byte_valid      = grp_r[idx_r].vld;
  assign out_last_of_message = grp_r[idx_r].last;
  assign out_status          = grp_r[idx_r].status;

endmodule

`default_nettype wire

FILE: src/hill_cipher_2x2_byte_stream.sv
// 2x2 hill cipher over bytes mod 256 with block-2 padding and unpadding
// top level: instantiates hc_matrix, hc_front and hc_core; uses hc_pkg
//
// input channel: one message byte per transfer (in_valid / in_stall), with
// in_end_of_message on the last byte. result channel: one result per transfer
// (out_valid / out_stall); a message ends with a result that has
// out_last_of_message set, and a nonzero out_status marks a failed message.
// config port: cfg_we writes cfg_data into the register at cfg_index
// (0..3 key a..d, 4 decrypt mode); the values are taken at each message start.
// a byte that completes a pair or ends a message passes the job register and
// then the result group register before its first result appears; the first
// byte of a message also waits while the working matrix (or its inverse mod
// 256) is set up. throughput: one result per cycle on the output while
// out_stall is low; an item gives up to four results, so a run of pairs
// sustains one byte per cycle, padding and the end of a message add results,
// and the input is stalled during that setup at each message start.
// reset clears all control state and loads the identity key in encrypt mode.
// a stall on the output holds the current result; one more job waits in the
// job register, after which the input is stalled.
`default_nettype none

module hill_cipher_2x2_byte_stream (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_end_of_message,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_byte_valid,
  output logic                           out_last_of_message,
  output logic [1:0]                     out_status,
  input  logic                           cfg_we,
  input  logic [hc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  hc_pkg::wm_t   wm;
  hc_pkg::mctl_t ctl;
  hc_pkg::job_t  job;
  logic          job_valid;
  logic          job_take;
  logic          start;

  hc_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start     (start),
    .wm        (wm),
    .ctl       (ctl)
  );

  hc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .ctl               (ctl),
    .job_take          (job_take),
    .start             (start),
    .job               (job),
    .job_valid         (job_valid)
  );

  hc_core u_core (
    .clk                 (clk),
    .rst_n               (rst_n),
    .job                 (job),
    .job_valid           (job_valid),
    .wm                  (wm),
    .ctl                 (ctl),
    .job_take            (job_take),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte            (out_byte),
    .out_byte_valid      (out_byte_valid),
    .out_last_of_message (out_last_of_message),
    .out_status          (out_status)
  );

endmodule

`default_nettype wire
